// ----- design/tdpt_pkg.sv -----
// Package for the trial-division prime test: widths, loop constants,
// sequencer states and the request/response types of the remainder unit.
// No dependencies.
package tdpt_pkg;

    // Width of the candidate field on the input channel and of the echo
    localparam int IN_BITS    = 32;
    // Width of the value actually tested
    localparam int VALUE_BITS = 32;

    // Divisor width: covers sqrt(2^VALUE_BITS) plus one stride of headroom
    localparam int D_BITS     = VALUE_BITS / 2 + 2;
    // Width of the running divisor square
    localparam int SQ_BITS    = 2 * D_BITS;

    // Remainder unit retires two dividend bits per cycle
    localparam int DIV_STEPS  = (VALUE_BITS + 1) / 2;
    localparam int PAD_BITS   = 2 * DIV_STEPS;
    localparam int CNT_BITS   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // 6k-1 / 6k+1 divisor walk
    localparam int FIRST_DIV  = 5;
    localparam int DIV_STRIDE = 6;
    localparam int PAIR_GAP   = 2;
    localparam int SMALL_DIV  = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCREEN,
        ST_MOD3,
        ST_BOUND,
        ST_MOD_LO,
        ST_MOD_HI,
        ST_FINISH
    } tdpt_state_t;

    // Request into the remainder unit
    typedef struct packed {
        logic              start;
        logic [D_BITS-1:0] divisor;
    } tdpt_rem_req_t;

    // Status out of the remainder unit
    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } tdpt_rem_rsp_t;

    // One restoring remainder step: shift in one dividend bit, subtract if it fits
    function automatic logic [D_BITS-1:0] rem_step(
        input logic [D_BITS-1:0] rem,
        input logic              din,
        input logic [D_BITS-1:0] divisor
    );
        logic [D_BITS:0] wide;
        logic [D_BITS:0] diff;
        begin
            wide = {rem, din};
            diff = wide - {1'b0, divisor};
            if (wide >= {1'b0, divisor})
            begin
                rem_step = diff[D_BITS-1:0];
            end
            else
            begin
                rem_step = wide[D_BITS-1:0];
            end
        end
    endfunction

endpackage

// ----- design/tdpt_if.sv -----
// Valid/ready channel interfaces for the candidate input and the verdict output.
// Depends on tdpt_pkg for field widths.
interface tdpt_cand_if;
    logic                         valid;
    logic                         ready;
    logic [tdpt_pkg::IN_BITS-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_res_if;
    logic                         valid;
    logic                         ready;
    logic [tdpt_pkg::IN_BITS-1:0] number_tested;
    logic                         is_prime;

    modport source (output valid, output number_tested, output is_prime, input ready);
    modport sink   (input valid, input number_tested, input is_prime, output ready);
endinterface

// ----- design/tdpt_rem_unit.sv -----
// Shared radix-4 restoring remainder unit: two dividend bits per cycle.
// Depends on tdpt_pkg (widths, rem_step, request/response structs).
module tdpt_rem_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tdpt_pkg::tdpt_rem_req_t            req,
    input  logic [tdpt_pkg::VALUE_BITS-1:0]    dividend,
    output tdpt_pkg::tdpt_rem_rsp_t            rsp
);
    import tdpt_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [D_BITS-1:0]   rem_reg;
    logic [D_BITS-1:0]   rem_next;
    logic [D_BITS-1:0]   rem_mid;
    logic [D_BITS-1:0]   div_reg;
    logic [PAD_BITS-1:0] sh_reg;

    // Retire the two top dividend bits
    always_comb
    begin
        rem_mid  = rem_step(rem_reg, sh_reg[PAD_BITS-1], div_reg);
        rem_next = rem_step(rem_mid, sh_reg[PAD_BITS-2], div_reg);
    end

    // Control: run DIV_STEPS steps per request, pulse done after the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands on start, then shift and reduce
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            div_reg <= req.divisor;
            sh_reg  <= PAD_BITS'(dividend);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            sh_reg  <= sh_reg << 2;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == '0);

endmodule

// ----- design/trial_division_prime_test.sv -----
// Top level of the trial-division prime test: sequencer, divisor walk and result register.
// Depends on tdpt_pkg, tdpt_if (channel interfaces) and tdpt_rem_unit.
//
//   channel | dir | handshake   | payload
//   --------+-----+-------------+--------------------------------
//   cand    | in  | valid/ready | candidate (32 bits)
//   res     | out | valid/ready | number_tested (32), is_prime (1)
//
// One candidate at a time; cand.ready is high only while the sequencer is idle.
// Values below 4 and even values resolve at the screen. Otherwise each trial
// divisor is run through the shared remainder unit, with two divisors per 6k
// step plus one bound check per step.
// Reset clears the sequencer and the result valid flag. A stalled result waits in
// its own register; the next candidate is taken as soon as the sequencer is idle.
module trial_division_prime_test (
    input  logic            clk,
    input  logic            rst_n,
    tdpt_cand_if.sink       cand,
    tdpt_res_if.source      res
);
    import tdpt_pkg::*;

    tdpt_state_t          state_reg;
    tdpt_state_t          state_next;
    logic [VALUE_BITS-1:0] n_reg;
    logic [D_BITS-1:0]     d_reg;
    logic [SQ_BITS-1:0]    sq_reg;
    logic                  verdict_reg;
    logic                  out_valid_reg;
    logic [IN_BITS-1:0]    out_num_reg;
    logic                  out_prime_reg;

    tdpt_rem_req_t rem_req;
    tdpt_rem_rsp_t rem_rsp;

    logic accept;
    logic init_loop;
    logic step_loop;
    logic set_verdict;
    logic verdict_val;
    logic load_result;
    logic bound_over;

    assign accept     = cand.valid && cand.ready;
    assign bound_over = sq_reg > SQ_BITS'(n_reg);

    tdpt_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (rem_req),
        .dividend (n_reg),
        .rsp      (rem_rsp)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCREEN;
                end
            end
            ST_SCREEN:
            begin
                if (n_reg < VALUE_BITS'(4) || !n_reg[0])
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MOD3;
                end
            end
            ST_MOD3:
            begin
                if (rem_rsp.done)
                begin
                    state_next = rem_rsp.zero ? ST_FINISH : ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                state_next = bound_over ? ST_FINISH : ST_MOD_LO;
            end
            ST_MOD_LO:
            begin
                if (rem_rsp.done)
                begin
                    state_next = rem_rsp.zero ? ST_FINISH : ST_MOD_HI;
                end
            end
            ST_MOD_HI:
            begin
                if (rem_rsp.done)
                begin
                    state_next = rem_rsp.zero ? ST_FINISH : ST_BOUND;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        cand.ready      = 1'b0;
        rem_req.start   = 1'b0;
        rem_req.divisor = d_reg;
        init_loop       = 1'b0;
        step_loop       = 1'b0;
        set_verdict     = 1'b0;
        verdict_val     = 1'b0;
        load_result     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cand.ready = 1'b1;
            end
            ST_SCREEN:
            begin
                init_loop = 1'b1;
                if (n_reg < VALUE_BITS'(2))
                begin
                    set_verdict = 1'b1;
                    verdict_val = 1'b0;
                end
                else if (n_reg < VALUE_BITS'(4))
                begin
                    set_verdict = 1'b1;
                    verdict_val = 1'b1;
                end
                else if (!n_reg[0])
                begin
                    set_verdict = 1'b1;
                    verdict_val = 1'b0;
                end
                else
                begin
                    rem_req.start   = 1'b1;
                    rem_req.divisor = D_BITS'(SMALL_DIV);
                end
            end
            ST_MOD3:
            begin
                if (rem_rsp.done && rem_rsp.zero)
                begin
                    set_verdict = 1'b1;
                    verdict_val = 1'b0;
                end
            end
            ST_BOUND:
            begin
                if (bound_over)
                begin
                    set_verdict = 1'b1;
                    verdict_val = 1'b1;
                end
                else
                begin
                    rem_req.start = 1'b1;
                end
            end
            ST_MOD_LO:
            begin
                if (rem_rsp.done)
                begin
                    if (rem_rsp.zero)
                    begin
                        set_verdict = 1'b1;
                        verdict_val = 1'b0;
                    end
                    else
                    begin
                        rem_req.start   = 1'b1;
                        rem_req.divisor = d_reg + D_BITS'(PAIR_GAP);
                    end
                end
            end
            ST_MOD_HI:
            begin
                if (rem_rsp.done)
                begin
                    if (rem_rsp.zero)
                    begin
                        set_verdict = 1'b1;
                        verdict_val = 1'b0;
                    end
                    else
                    begin
                        step_loop = 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                load_result = !out_valid_reg || res.ready;
            end
            default:
            begin
                cand.ready = 1'b0;
            end
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture candidate, advance divisor and its square, record verdict, load result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n_reg <= VALUE_BITS'(cand.candidate);
        end
        if (init_loop)
        begin
            d_reg  <= D_BITS'(FIRST_DIV);
            sq_reg <= SQ_BITS'(FIRST_DIV * FIRST_DIV);
        end
        else if (step_loop)
        begin
            d_reg  <= d_reg + D_BITS'(DIV_STRIDE);
            sq_reg <= sq_reg + SQ_BITS'(2 * DIV_STRIDE) * SQ_BITS'(d_reg)
                      + SQ_BITS'(DIV_STRIDE * DIV_STRIDE);
        end
        if (set_verdict)
        begin
            verdict_reg <= verdict_val;
        end
        if (load_result)
        begin
            out_num_reg   <= IN_BITS'(n_reg);
            out_prime_reg <= verdict_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.number_tested = out_num_reg;
    assign res.is_prime      = out_prime_reg;

endmodule

// ----- sim/tb_trial_division_prime_test.sv -----
// Testbench for trial_division_prime_test: drives candidates, predicts each verdict
// and checks every returned beat in order. Depends on tdpt_pkg and tdpt_if.
module tb_trial_division_prime_test;

    import tdpt_pkg::*;

    localparam int GAP_MAX       = 18;
    localparam int HOLD_CYCLES   = 500;
    localparam int DRAIN_CYCLES  = 40;
    localparam int IDLE_LIMIT    = 1500000;
    localparam int RANDOM_ITEMS  = 72;
    localparam int BURST_ITEMS   = 8;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [IN_BITS-1:0] number;
        logic               prime;
    } verdict_t;

    // Expected verdicts in arrival order, plus the primality predictor
    class verdict_board;
        verdict_t    pending_q[$];
        int unsigned checked;
        int unsigned primes;
        int unsigned mismatches;

        function bit predict_prime(input logic [63:0] n);
            logic [63:0] d;
            if (n <= 1)
            begin
                return 1'b0;
            end
            if (n <= SMALL_DIV)
            begin
                return 1'b1;
            end
            if ((n % 2) == 0 || (n % SMALL_DIV) == 0)
            begin
                return 1'b0;
            end
            // Walk the 6k-1 / 6k+1 pairs while d*d <= n
            for (d = FIRST_DIV; d <= n / d; d += DIV_STRIDE)
            begin
                if ((n % d) == 0 || (n % (d + PAIR_GAP)) == 0)
                begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_candidate(input logic [IN_BITS-1:0] cand);
            logic [63:0] mask;
            logic [63:0] n;
            verdict_t    v;
            mask = (VALUE_BITS >= 64) ? ~64'd0 : ((64'd1 << VALUE_BITS) - 64'd1);
            n = {{(64 - IN_BITS){1'b0}}, cand} & mask;
            v.number = n[IN_BITS-1:0];
            v.prime  = predict_prime(n);
            pending_q = {pending_q, v};
        endfunction

        function void check_result(input logic [IN_BITS-1:0] number, input logic prime);
            verdict_t want;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("unexpected verdict: number_tested=%h is_prime=%0d",
                             number, prime);
                end
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (want.prime)
            begin
                primes++;
            end
            if (number !== want.number || prime !== want.prime)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("verdict mismatch: expected number=%h prime=%0d,",
                             want.number, want.prime,
                             " got number=%h prime=%0d", number, prime);
                end
            end
        endfunction

        function int unsigned outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tdpt_cand_if cand_ch();
    tdpt_res_if  res_ch();

    trial_division_prime_test dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cand  (cand_ch),
        .res   (res_ch)
    );

    verdict_board board = new();

    bit          quick_stretch;
    bit          hold_req;
    int unsigned sent;
    int unsigned idle_cycles;

    // Small primes used to build large composites that resolve quickly
    int unsigned small_factors[16] = '{5, 7, 11, 13, 17, 19, 23, 29,
                                       31, 37, 41, 43, 47, 53, 59, 97};

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if ((cand_ch.valid && cand_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d verdicts outstanding",
                     idle_cycles, board.outstanding());
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one candidate, holding valid until the beat is taken
    task automatic offer_candidate(input logic [IN_BITS-1:0] value, input bit no_gap);
        int unsigned gap;
        gap = (no_gap || quick_stretch) ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            cand_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cand_ch.valid     <= 1'b1;
        cand_ch.candidate <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cand_ch.ready);
        board.note_candidate(value);
        sent++;
    endtask

    // Hold the sender until every expected verdict has returned
    task automatic drain_verdicts();
        cand_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Draw a candidate: mostly values that reach the divisor walk, some noise
    function automatic logic [IN_BITS-1:0] draw_candidate();
        int unsigned r;
        int unsigned w;
        int unsigned f;
        logic [31:0] v;
        logic [31:0] m;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            // short value, mostly odd, walked to completion
            w = $urandom_range(2, 16);
            v = $urandom & ((32'd1 << w) - 32'd1);
            if ($urandom_range(0, 9) < 8)
            begin
                v[0] = 1'b1;
            end
        end
        else if (r < 70)
        begin
            // full-width composite with a small factor
            f = small_factors[$urandom_range(0, 15)];
            m = $urandom_range(1, 32'hFFFF_FFFF / f);
            v = f * m;
        end
        else if (r < 85)
        begin
            // full-width multiple of 2 or 3, caught by the screen or the mod-3 check
            v = $urandom;
            if ($urandom_range(0, 1) == 0)
            begin
                v[0] = 1'b0;
            end
            else
            begin
                v = v - (v % SMALL_DIV);
            end
        end
        else if (r < 95)
        begin
            // medium odd value, longer walk
            w = $urandom_range(17, 21);
            v = ($urandom & ((32'd1 << w) - 32'd1)) | 32'd1;
        end
        else
        begin
            v = $urandom_range(0, 4);
        end
        return v[IN_BITS-1:0];
    endfunction

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        int unsigned gap;
        bit          hold_done;
        hold_done = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                gap = HOLD_CYCLES;
            end
            else if (quick_stretch)
            begin
                gap = 0;
            end
            else
            begin
                gap = $urandom_range(0, GAP_MAX);
            end
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!res_ch.valid);
            board.check_result(res_ch.number_tested, res_ch.is_prime);
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [IN_BITS-1:0] directed[$];
        logic [IN_BITS-1:0] v;
        quick_stretch = 1'b0;
        hold_req      = 1'b0;
        sent          = 0;
        rst_n             <= 1'b0;
        cand_ch.valid     <= 1'b0;
        cand_ch.candidate <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: trivial values, screen cases, squares at the bound, both
        // divisors of a pair, large prime and large composites
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9,
                     32'd25, 32'd35, 32'd49, 32'd121, 32'd143, 32'd169, 32'd289,
                     32'd323, 32'd10403, 32'd65521, 32'h7FFF_FFFF, 32'hFFFF_FFFD,
                     32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h8000_0000};
        foreach (directed[i])
        begin
            offer_candidate(directed[i], 1'b0);
        end
        drain_verdicts();

        // Random phase with a gap-free stretch, a receiver hold-off and a pause
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quick_stretch = (i >= 20 && i < 35);
            if (i == 50)
            begin
                hold_req = 1'b1;
                for (int k = 0; k < BURST_ITEMS; k++)
                begin
                    v = $urandom_range(0, 255);
                    offer_candidate(v, 1'b1);
                end
            end
            if (i == 70)
            begin
                drain_verdicts();
            end
            offer_candidate(draw_candidate(), 1'b0);
        end
        cand_ch.valid <= 1'b0;
        quick_stretch = 1'b0;

        // Wait for the last verdicts, then watch for strays
        while (board.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d candidates, checked %0d verdicts (%0d prime), %0d mismatches;",
                 sent, board.checked, board.primes, board.mismatches);
        $display("covered screen cases, bound squares, large values, stalls and a long hold-off");
        if (board.mismatches == 0 && board.outstanding() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
